@@ hw/rtl/uer_pkg.sv @@
// Shared constants for the ultrasonic echo ranger: phase codes,
// configuration register indexes, field widths and register reset values.
// No dependencies.
`timescale 1ns / 1ps

package uer_pkg;

  // Measurement phases
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_LOW  = 3'd1;
  localparam logic [2:0] PH_HIGH = 3'd2;
  localparam logic [2:0] PH_WAIT = 3'd3;
  localparam logic [2:0] PH_MEAS = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_TRIG_LOW  = 2'd0;
  localparam logic [1:0] REG_TRIG_HIGH = 2'd1;
  localparam logic [1:0] REG_TIMEOUT   = 2'd2;
  localparam logic [1:0] REG_US_PER_CM = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam int TIMEOUT_W  = 20;
  localparam int SHORT_W    = 8;
  localparam int DIST_OUT_W = 16;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;

  // Register values after reset
  localparam logic [SHORT_W-1:0]   RST_TRIG_LOW  = 8'd2;
  localparam logic [SHORT_W-1:0]   RST_TRIG_HIGH = 8'd10;
  localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT   = 20'd60000;
  localparam logic [SHORT_W-1:0]   RST_US_PER_CM = 8'd58;

endpackage

@@ hw/rtl/ultrasonic_echo_ranger.sv @@
// Ultrasonic echo ranger top level: trigger sequencing, echo timing and
// distance counting. Depends on uer_pkg.
`timescale 1ns / 1ps

// Each accepted request is one microsecond tick carrying the sampled echo
// level and a start flag; each tick produces exactly one result carrying
// the trigger pin level, busy, a distance-valid strobe, a timeout strobe
// and the distance in whole centimetres. A start while idle holds the
// trigger low for trigger_low_us ticks, pulses it high for trigger_high_us
// ticks, then waits for the echo to rise and counts how long it stays high.
// The distance is floor(high ticks / us_per_cm), built up by a sub-counter
// that rolls over every us_per_cm ticks, and saturates at
// 2^DISTANCE_WIDTH - 1 (the port carries its low 16 bits). Each echo wait
// times out on its (echo_timeout_us + 1)-th tick. Rate: one request per
// clock cycle unless stalled; each result enters the output register
// as its request is accepted, and s_tready drops only while that register
// holds a result the downstream side has not taken. Configuration writes
// are always accepted and must be made while no measurement is running.
module ultrasonic_echo_ranger
  import uer_pkg::*;
#(
  parameter int TIMER_WIDTH    = 20,
  parameter int DISTANCE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // tick requests
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [0] echo_level, [1] start_request
  // results
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // [0] trigger_level, [1] busy_res,
                                            // [2] result_valid, [3] timed_out,
                                            // [19:4] range_cm
);

  localparam int CMP_W = (TIMER_WIDTH > TIMEOUT_W) ? TIMER_WIDTH : TIMEOUT_W;

  // Configuration registers
  logic [SHORT_W-1:0]   trigger_low_us;
  logic [SHORT_W-1:0]   trigger_high_us;
  logic [TIMEOUT_W-1:0] echo_timeout_us;
  logic [SHORT_W-1:0]   us_per_cm;

  // Measurement state
  logic [2:0]                phase, phase_next;
  logic [TIMER_WIDTH-1:0]    phase_ticks, phase_ticks_next;
  logic [SHORT_W-1:0]        cm_fraction_ticks, cm_fraction_ticks_next;
  logic [DISTANCE_WIDTH-1:0] cm_count, cm_count_next;

  // Result fields of the tick being accepted
  logic                  trig_c, valid_c, tout_c;
  logic [DIST_OUT_W-1:0] dist_c;
  logic                  echo, start, accept;

  // Echo-wait limit reached: ticks at the timeout, or at the counter's top
  // when the timeout is larger than the counter can hold.
  logic wait_expired;

  assign echo   = s_tdata[0];
  assign start  = s_tdata[1];
  assign accept = s_tvalid && s_tready;

  assign cfg_ready = 1'b1;
  // Take a new tick whenever the output register is empty or draining.
  assign s_tready  = !m_tvalid || m_tready;

  assign wait_expired = (CMP_W'(phase_ticks) >= CMP_W'(echo_timeout_us)) ||
                        (phase_ticks == {TIMER_WIDTH{1'b1}});

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_low_us  <= RST_TRIG_LOW;
      trigger_high_us <= RST_TRIG_HIGH;
      echo_timeout_us <= RST_TIMEOUT;
      us_per_cm       <= RST_US_PER_CM;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TRIG_LOW:  trigger_low_us  <= cfg_data[SHORT_W-1:0];
        REG_TRIG_HIGH: trigger_high_us <= cfg_data[SHORT_W-1:0];
        REG_TIMEOUT:   echo_timeout_us <= cfg_data[TIMEOUT_W-1:0];
        REG_US_PER_CM: us_per_cm       <= cfg_data[SHORT_W-1:0];
        default: ;
      endcase
    end
  end

  // One tick: a phase that completes hands the same tick to the next phase,
  // so the checks run in order and each sees the updated phase.
  always_comb begin
    phase_next             = phase;
    phase_ticks_next       = phase_ticks;
    cm_fraction_ticks_next = cm_fraction_ticks;
    cm_count_next          = cm_count;
    trig_c  = 1'b0;
    valid_c = 1'b0;
    tout_c  = 1'b0;
    dist_c  = '0;

    if (phase_next == PH_IDLE && start) begin
      phase_next       = PH_LOW;
      phase_ticks_next = '0;
    end

    if (phase_next == PH_LOW) begin
      if (phase_ticks_next >= TIMER_WIDTH'(trigger_low_us)) begin
        phase_next       = PH_HIGH;
        phase_ticks_next = '0;
      end else begin
        phase_ticks_next = phase_ticks_next + TIMER_WIDTH'(1);
      end
    end

    if (phase_next == PH_HIGH) begin
      if (phase_ticks_next >= TIMER_WIDTH'(trigger_high_us)) begin
        phase_next       = PH_WAIT;
        phase_ticks_next = '0;
      end else begin
        phase_ticks_next = phase_ticks_next + TIMER_WIDTH'(1);
        trig_c           = 1'b1;
      end
    end

    // Entering the wait in this tick means ticks start from zero, which
    // never meets the limit unless the timeout is zero.
    if (phase_next == PH_WAIT) begin
      if (echo) begin
        phase_next             = PH_MEAS;
        phase_ticks_next       = '0;
        cm_fraction_ticks_next = '0;
        cm_count_next          = '0;
      end else if ((phase == PH_WAIT) ? wait_expired
                                      : (echo_timeout_us == '0)) begin
        tout_c           = 1'b1;
        phase_next       = PH_IDLE;
        phase_ticks_next = '0;
      end else begin
        phase_ticks_next = phase_ticks_next + TIMER_WIDTH'(1);
      end
    end

    if (phase_next == PH_MEAS) begin
      if (!echo) begin
        valid_c          = 1'b1;
        dist_c           = DIST_OUT_W'(cm_count_next);
        phase_next       = PH_IDLE;
        phase_ticks_next = '0;
      end else if ((phase == PH_MEAS) ? wait_expired
                                      : (echo_timeout_us == '0)) begin
        tout_c           = 1'b1;
        phase_next       = PH_IDLE;
        phase_ticks_next = '0;
      end else begin
        phase_ticks_next       = phase_ticks_next + TIMER_WIDTH'(1);
        cm_fraction_ticks_next = cm_fraction_ticks_next + SHORT_W'(1);
        // Roll the sub-counter over once a whole centimetre has passed.
        if (cm_fraction_ticks_next >= us_per_cm) begin
          cm_fraction_ticks_next = '0;
          if (cm_count_next != {DISTANCE_WIDTH{1'b1}}) begin
            cm_count_next = cm_count_next + DISTANCE_WIDTH'(1);
          end
        end
      end
    end

    // Drop any code outside the phase set back to idle.
    if (phase_next > PH_MEAS) begin
      phase_next = PH_IDLE;
    end
  end

  // Advance state on every accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      phase_ticks       <= '0;
      cm_fraction_ticks <= '0;
      cm_count          <= '0;
    end else if (accept) begin
      phase             <= phase_next;
      phase_ticks       <= phase_ticks_next;
      cm_fraction_ticks <= cm_fraction_ticks_next;
      cm_count          <= cm_count_next;
    end
  end

  // Output register: hold the result until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {4'b0000, dist_c, tout_c, valid_c,
                  (phase_next != PH_IDLE), trig_c};
    end
  end

endmodule

@@ sim/tb_ultrasonic_echo_ranger.sv @@
// Self-checking testbench for ultrasonic_echo_ranger: a tick-level predictor in
// a small scoreboard class, plus tasks that drive ticks and register writes.
// Depends on uer_pkg and the ultrasonic_echo_ranger RTL.
`timescale 1ns / 1ps

import uer_pkg::*;

// Packed from the top bit down, so trigger_level lands in bit 0.
typedef struct packed {
  logic [DIST_OUT_W-1:0] range_cm;
  logic                  timed_out;
  logic                  distance_valid;
  logic                  busy;
  logic                  trigger_level;
} tick_result_t;

class ranger_scoreboard;
  // register copies
  logic [SHORT_W-1:0]   low_cfg;
  logic [SHORT_W-1:0]   pulse_cfg;
  logic [TIMEOUT_W-1:0] timeout_cfg;
  logic [SHORT_W-1:0]   scale_cfg;
  // ranger state
  logic [2:0]           phase_now;
  logic [19:0]          phase_ticks;
  logic [7:0]           cm_fraction;
  logic [15:0]          cm_count;

  tick_result_t         pending_results[$];
  int                   mismatches;
  int                   results_seen;

  function new();
    low_cfg     = RST_TRIG_LOW;
    pulse_cfg   = RST_TRIG_HIGH;
    timeout_cfg = RST_TIMEOUT;
    scale_cfg   = RST_US_PER_CM;
    phase_now   = PH_IDLE;
    phase_ticks = '0;
    cm_fraction = '0;
    cm_count    = '0;
    mismatches  = 0;
    results_seen = 0;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_TRIG_LOW:  low_cfg = val[SHORT_W-1:0];
      REG_TRIG_HIGH: pulse_cfg = val[SHORT_W-1:0];
      REG_TIMEOUT:   timeout_cfg = val[TIMEOUT_W-1:0];
      REG_US_PER_CM: scale_cfg = val[SHORT_W-1:0];
      default: ;
    endcase
  endfunction

  // Advance one microsecond tick; a phase that finishes hands the same tick
  // on to the next phase.
  function void note_tick(bit echo, bit start);
    tick_result_t r;
    r = '0;
    if (phase_now == PH_IDLE && start) begin
      phase_now = PH_LOW;
      phase_ticks = '0;
    end
    if (phase_now == PH_LOW) begin
      if (phase_ticks >= low_cfg) begin
        phase_now = PH_HIGH;
        phase_ticks = '0;
      end else begin
        phase_ticks++;
      end
    end
    if (phase_now == PH_HIGH) begin
      if (phase_ticks >= pulse_cfg) begin
        phase_now = PH_WAIT;
        phase_ticks = '0;
      end else begin
        phase_ticks++;
        r.trigger_level = 1'b1;
      end
    end
    if (phase_now == PH_WAIT) begin
      if (echo) begin
        phase_now = PH_MEAS;
        phase_ticks = '0;
        cm_fraction = '0;
        cm_count = '0;
      end else if (phase_ticks >= timeout_cfg) begin
        r.timed_out = 1'b1;
        phase_now = PH_IDLE;
        phase_ticks = '0;
      end else begin
        phase_ticks++;
      end
    end
    if (phase_now == PH_MEAS) begin
      if (!echo) begin
        r.distance_valid = 1'b1;
        r.range_cm = cm_count;
        phase_now = PH_IDLE;
        phase_ticks = '0;
      end else if (phase_ticks >= timeout_cfg) begin
        r.timed_out = 1'b1;
        phase_now = PH_IDLE;
        phase_ticks = '0;
      end else begin
        phase_ticks++;
        cm_fraction++;
        // a zero scale rolls over every tick, same as a scale of one
        if (cm_fraction >= scale_cfg) begin
          cm_fraction = '0;
          if (cm_count != 16'hFFFF) cm_count++;
        end
      end
    end
    r.busy = (phase_now != PH_IDLE);
    pending_results.push_back(r);
  endfunction

  task report(string what, longint got, longint want);
    if (mismatches < 40)
      $display("result %0d: %s got %0h expected %0h", results_seen, what, got, want);
    mismatches++;
  endtask

  task check_result(logic [OUT_TDATA_W-1:0] word);
    tick_result_t want;
    tick_result_t got;
    got = word[19:0];
    if (pending_results.size() == 0) begin
      report("unexpected result", word, 0);
    end else begin
      want = pending_results.pop_front();
      if (got.trigger_level !== want.trigger_level)
        report("trigger_level", got.trigger_level, want.trigger_level);
      if (got.busy !== want.busy)
        report("busy_res", got.busy, want.busy);
      if (got.distance_valid !== want.distance_valid)
        report("result_valid", got.distance_valid, want.distance_valid);
      if (got.timed_out !== want.timed_out)
        report("timed_out", got.timed_out, want.timed_out);
      if (got.range_cm !== want.range_cm)
        report("range_cm", got.range_cm, want.range_cm);
    end
    results_seen++;
  endtask
endclass

module tb_ultrasonic_echo_ranger;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int TOTAL_TICKS = 1400;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // [0] echo_level, [1] start_request
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // [0] trigger_level, [1] busy_res,
                                          // [2] result_valid, [3] timed_out,
                                          // [19:4] range_cm

  ranger_scoreboard sb = new();

  // idling switches, flipped per phase so some stretches run back to back
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;
  int ticks_sent = 0;
  int cycle_count = 0;

  ultrasonic_echo_ranger dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Bound the run; a hang anywhere ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ultrasonic_echo_ranger verification failed");
      $finish;
    end
  end

  // Downstream side: stall a random number of cycles before taking each
  // result, then check it against the oldest predicted tick.
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = stalls_on ? $urandom_range(0, 16) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_result(m_tdata);
    end
  end

  // Send one tick request; valid stays up afterwards so a following request
  // can go out back to back. Predict it once it is taken.
  task automatic send_tick(input bit echo, input bit start);
    int gap;
    gap = gaps_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= IN_TDATA_W'({start, echo});
    do @(posedge clk); while (!s_tready);
    sb.note_tick(echo, start);
    ticks_sent++;
  endtask

  // Run the ranger back to idle, drop valid and wait for every result.
  // An echo wait ends fastest by raising the echo and dropping it next tick.
  task automatic quiesce();
    while (sb.phase_now != PH_IDLE) send_tick(sb.phase_now == PH_WAIT, 1'b0);
    s_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx,
                         input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
  endtask

  // Write all four registers; call only with the ranger idle and drained.
  task automatic apply_settings(input int low, input int pulse, input int tmo,
                                input int scale);
    put_reg(REG_TRIG_LOW, CFG_DATA_W'(low));
    put_reg(REG_TRIG_HIGH, CFG_DATA_W'(pulse));
    put_reg(REG_TIMEOUT, CFG_DATA_W'(tmo));
    put_reg(REG_US_PER_CM, CFG_DATA_W'(scale));
    cfg_valid <= 1'b0;
  endtask

  // One measurement: start, trigger ticks with a random (ignored) echo, up to
  // wait_len quiet ticks, up to high_len echo-high ticks, then the falling
  // edge. Stray starts land on busy ticks and on the finishing tick.
  task automatic run_measurement(input int wait_len, input int high_len);
    int n;
    send_tick(1'($urandom_range(0, 1)), 1'b1);
    while (sb.phase_now == PH_LOW || sb.phase_now == PH_HIGH)
      send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    n = 0;
    while (sb.phase_now == PH_WAIT && n < wait_len) begin
      send_tick(1'b0, 1'($urandom_range(0, 1)));
      n++;
    end
    n = 0;
    while (sb.phase_now != PH_IDLE && n < high_len) begin
      send_tick(1'b1, 1'($urandom_range(0, 1)));
      n++;
    end
    if (sb.phase_now != PH_IDLE) send_tick(1'b0, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int low;
    int pulse;
    int tmo;
    int scale;
    int wait_cap;
    int high_cap;

    // Hold reset once, at the start of the run.
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: a measurement on the reset values, echo ignored during trigger
    run_measurement(1, 4);

    // Zero everything: no low phase, no pulse, immediate timeouts, unit scale
    quiesce();
    apply_settings(0, 0, 0, 0);
    send_tick(1'b0, 1'b1);   // times out in the start tick itself
    send_tick(1'b1, 1'b1);   // echo already high: measure phase times out
    quiesce();

    // Short timeout: a clean distance, a wait timeout, an echo-high timeout
    apply_settings(1, 1, 3, 0);
    run_measurement(2, 3);
    run_measurement(6, 0);
    run_measurement(0, 6);
    quiesce();

    // Pulse of zero ticks skips the trigger pulse
    apply_settings(0, 0, 5, 2);
    run_measurement(0, 5);
    quiesce();

    // Upper extremes of every register; run back to back to keep it short
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    apply_settings(255, 255, 20'hFFFFF, 255);
    run_measurement(3, 520);
    quiesce();

    // Random phases: fresh settings, then mostly well-formed measurements
    // with random lengths and some random noise ticks.
    while (ticks_sent < TOTAL_TICKS) begin
      quiesce();
      low = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 5);
      pulse = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 5);
      case ($urandom_range(0, 3))
        0: tmo = $urandom_range(0, 3);
        3: tmo = $urandom_range(41, 400);
        default: tmo = $urandom_range(4, 40);
      endcase
      scale = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 255) : $urandom_range(0, 9);
      apply_settings(low, pulse, tmo, scale);
      gaps_on = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      wait_cap = (tmo + 2 > 60) ? 60 : tmo + 2;
      high_cap = (tmo + 2 > 80) ? 80 : tmo + 2;
      repeat ($urandom_range(3, 8)) begin
        if ($urandom_range(0, 4) != 0)
          run_measurement($urandom_range(0, wait_cap), $urandom_range(0, high_cap));
        else
          repeat ($urandom_range(1, 8))
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end

    // Drain, then give any stray result a few cycles to show up.
    quiesce();
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("ultrasonic_echo_ranger verification clean");
    end else begin
      $display("ultrasonic_echo_ranger verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/uer_pkg.sv
hw/rtl/ultrasonic_echo_ranger.sv
sim/tb_ultrasonic_echo_ranger.sv
